// File: sv/clpd_pkg.sv
package clpd_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_CHECK,
        ST_RUN,
        ST_DIFF,
        ST_ARC,
        ST_EMIT
    } clpd_state_t;

    typedef enum logic [1:0] {
        REG_BRIGHT_OFFSET,
        REG_SIDE_DIFF_LIMIT,
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT
    } clpd_reg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic shift;
        logic init;
        logic run;
        logic arc_init;
        logic arc_step;
        logic emit;
    } clpd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic eligible;
        logic run_go;
        logic run_hit;
        logic diff_ok;
        logic arc_last;
        logic out_free;
    } clpd_sts_t;

    typedef struct packed {
        logic [7:0]  bright_offset;
        logic [7:0]  side_diff_limit;
        logic [10:0] image_width;
        logic [10:0] image_height;
    } clpd_cfg_t;

    localparam int CFG_DATA_W = 11;
    localparam int CFG_INDEX_W = 2;

    localparam logic [7:0]  BRIGHT_OFFSET_RST   = 8'd20;
    localparam logic [7:0]  SIDE_DIFF_LIMIT_RST = 8'd20;
    localparam logic [10:0] IMAGE_WIDTH_RST     = 11'd640;
    localparam logic [10:0] IMAGE_HEIGHT_RST    = 11'd480;

    localparam int MIN_DIM = 7;
    localparam int WIN = 7;
    localparam int LINES = 6;
    localparam int RUN_LEN = 5;
    localparam int ARC_LAST = 2;

    localparam logic signed [8:0] NO_DIR = -9'sd181;

    localparam logic signed [2:0] CIRC_X [16] =
        '{-3, -3, -2, -1, 0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3};
    localparam logic signed [2:0] CIRC_Y [16] =
        '{0, -1, -2, -3, -3, -3, -2, -1, 0, 1, 2, 3, 3, 3, 2, 1};

    localparam logic [7:0] WRAP_MASK [8] =
        '{8'h0E, 8'h1C, 8'h38, 8'h70, 8'hE0, 8'hC1, 8'h83, 8'h07};

    // Floor of atan2(ay, ax) in degrees, indexed [ay][ax].
    localparam logic [7:0] QUAD_DEG [7][7] = '{
        '{8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0},
        '{8'd90, 8'd45, 8'd26, 8'd18, 8'd14, 8'd11, 8'd9},
        '{8'd90, 8'd63, 8'd45, 8'd33, 8'd26, 8'd21, 8'd18},
        '{8'd90, 8'd71, 8'd56, 8'd45, 8'd36, 8'd30, 8'd26},
        '{8'd90, 8'd75, 8'd63, 8'd53, 8'd45, 8'd38, 8'd33},
        '{8'd90, 8'd78, 8'd68, 8'd59, 8'd51, 8'd45, 8'd39},
        '{8'd90, 8'd80, 8'd71, 8'd63, 8'd56, 8'd50, 8'd45}
    };

    // Direction of (dx, dy) folded into whole degrees 0..180.
    function automatic logic signed [8:0] fold_angle(logic signed [3:0] dx,
                                                     logic signed [3:0] dy);
        logic [2:0] ax;
        logic [2:0] ay;
        logic [7:0] q;
        logic       exact;
        logic [7:0] d;
        ax = dx[3] ? 3'(-dx) : 3'(dx);
        ay = dy[3] ? 3'(-dy) : 3'(dy);
        if (ax > 3'd6) ax = 3'd6;
        if (ay > 3'd6) ay = 3'd6;
        q = QUAD_DEG[ay][ax];
        exact = (ax == 3'd0) || (ay == 3'd0) || (ax == ay);
        if (!dx[3]) d = q;
        else if (exact) d = 8'd180 - q;
        else d = 8'd179 - q;
        if (!dy[3]) return signed'({1'b0, d});
        return signed'(9'd179 - {1'b0, d});
    endfunction

endpackage

// File: sv/clpd_pixel_if.sv
interface clpd_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_value;
    logic       frame_start;

    modport source (output valid, output pixel_value, output frame_start, input ready);
    modport sink (input valid, input pixel_value, input frame_start, output ready);
endinterface

// File: sv/clpd_point_if.sv
interface clpd_point_if;
    logic              valid;
    logic              ready;
    logic [9:0]        point_row;
    logic [9:0]        point_col;
    logic signed [8:0] angle_deg;
    logic [7:0]        point_score;

    modport source (output valid, output point_row, output point_col, output angle_deg,
                    output point_score, input ready);
    modport sink (input valid, input point_row, input point_col, input angle_deg,
                  input point_score, output ready);
endinterface

// File: sv/circle_line_point_detector.sv
// Circle line-point detector on a raster stream of 8-bit pixels.
// The pixel channel takes one item per pixel in raster order; frame_start
// marks row 0, column 0 of a new frame. Six line banks and a 7x7 window
// present each centre three rows and columns behind the newest pixel. A
// centre at least three pixels from every border is tested on the radius-3
// 16-point circle; a hit gives one item on the point channel with row,
// column, direction in degrees (-181 when no direction) and score.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user
// must write it only while the block is idle, which the block does not enforce.
// Each pixel is accepted and then shifted into the window. A tested centre
// is set up, then the run search visits circle positions (at most 64),
// stepping one opposite pair per cycle, before it is left; a run hit then
// goes through the side check, the arc search when the sides balance, and
// the load of the result register. The result register keeps its item
// while the receiver stalls; the block takes the next pixel meanwhile and
// holds only when a new result is ready and the register is still full.
// Reset clears the raster counters, the result valid flag and restores the
// register defaults; line banks and window contents are undefined until
// written by the stream.
module circle_line_point_detector #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    clpd_pixel_if.sink                         pixel,
    clpd_point_if.source                       point,
    input  logic                               cfg_we,
    input  logic [clpd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [clpd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import clpd_pkg::*;

    clpd_cfg_t cfg_reg;
    clpd_cmd_t cmd;
    clpd_sts_t sts;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bright_offset <= BRIGHT_OFFSET_RST;
            cfg_reg.side_diff_limit <= SIDE_DIFF_LIMIT_RST;
            cfg_reg.image_width <= IMAGE_WIDTH_RST;
            cfg_reg.image_height <= IMAGE_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (clpd_reg_t'(cfg_index))
                REG_BRIGHT_OFFSET:   cfg_reg.bright_offset <= cfg_data[7:0];
                REG_SIDE_DIFF_LIMIT: cfg_reg.side_diff_limit <= cfg_data[7:0];
                REG_IMAGE_WIDTH:     cfg_reg.image_width <= cfg_data;
                REG_IMAGE_HEIGHT:    cfg_reg.image_height <= cfg_data;
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    clpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixel.valid),
        .in_ready (pixel.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    clpd_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .cmd         (cmd),
        .sts         (sts),
        .pixel_value (pixel.pixel_value),
        .frame_start (pixel.frame_start),
        .out_ready   (point.ready),
        .out_valid   (point.valid),
        .point_row   (point.point_row),
        .point_col   (point.point_col),
        .angle_deg   (point.angle_deg),
        .point_score (point.point_score)
    );

    // A result is loaded only into a free or draining result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!point.valid || point.ready))
        else $error("result loaded over a held result");

    // One pixel at a time: after an accept the input side closes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pixel.valid && pixel.ready) |=> !pixel.ready)
        else $error("input reopened while a pixel is in work");

    // A result only appears after a load command.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(point.valid) |-> $past(cmd.emit))
        else $error("result valid without a load");

    // The run search and the arc search never overlap with an accept.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.run || cmd.arc_step) |-> !pixel.ready)
        else $error("search active while input is open");

endmodule

// File: sv/clpd_ctrl.sv
module clpd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  clpd_pkg::clpd_sts_t sts,
    output clpd_pkg::clpd_cmd_t cmd
);
    import clpd_pkg::*;

    clpd_state_t state_reg;
    clpd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                state_next = sts.eligible ? ST_CHECK : ST_IDLE;
            end
            ST_CHECK:
            begin
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (!sts.run_go) state_next = sts.run_hit ? ST_DIFF : ST_IDLE;
            end
            ST_DIFF:
            begin
                state_next = sts.diff_ok ? ST_ARC : ST_EMIT;
            end
            ST_ARC:
            begin
                if (sts.arc_last) state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.accept = in_valid;
            end
            ST_SHIFT: cmd.shift = 1'b1;
            ST_CHECK: cmd.init = 1'b1;
            ST_RUN:   cmd.run = sts.run_go;
            ST_DIFF:  cmd.arc_init = 1'b1;
            ST_ARC:   cmd.arc_step = 1'b1;
            ST_EMIT:  cmd.emit = sts.out_free;
            default:  cmd = '0;
        endcase
    end

endmodule

// File: sv/clpd_dp.sv
module clpd_dp #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  clpd_pkg::clpd_cfg_t cfg,
    input  clpd_pkg::clpd_cmd_t cmd,
    output clpd_pkg::clpd_sts_t sts,
    input  logic [7:0]          pixel_value,
    input  logic                frame_start,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [9:0]          point_row,
    output logic [9:0]          point_col,
    output logic signed [8:0]   angle_deg,
    output logic [7:0]          point_score
);
    import clpd_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int DWA = $clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1) ?
                         $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
    localparam int DW = (DWA > CFG_DATA_W ? DWA : CFG_DATA_W) + 1;

    // Raster position.
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [2:0]    slot_reg, slot_next;
    logic [CW-1:0] col_pos_reg;
    logic [RW-1:0] row_pos_reg;
    logic [2:0]    slot_pos_reg;
    logic [7:0]    pix_reg;

    logic [DW-1:0] w_dim, h_dim;
    logic [DW-1:0] c0, r0, c1, r1, r2, cn, rn;
    logic [2:0]    m0, m1, m2, mn;

    function automatic logic [2:0] slot_inc(logic [2:0] m);
        return (m == 3'(LINES - 1)) ? 3'd0 : m + 3'd1;
    endfunction

    always_comb
    begin
        w_dim = (cfg.image_width < CFG_DATA_W'(MIN_DIM)) ? DW'(MIN_DIM) :
                (DW'(cfg.image_width) > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) :
                DW'(cfg.image_width);
        h_dim = (cfg.image_height < CFG_DATA_W'(MIN_DIM)) ? DW'(MIN_DIM) :
                (DW'(cfg.image_height) > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) :
                DW'(cfg.image_height);
        c0 = frame_start ? '0 : DW'(col_reg);
        r0 = frame_start ? '0 : DW'(row_reg);
        m0 = frame_start ? 3'd0 : slot_reg;
        if (c0 >= w_dim)
        begin
            c1 = '0;
            r1 = r0 + DW'(1);
            m1 = slot_inc(m0);
        end
        else
        begin
            c1 = c0;
            r1 = r0;
            m1 = m0;
        end
        if (r1 >= h_dim)
        begin
            r2 = '0;
            m2 = 3'd0;
        end
        else
        begin
            r2 = r1;
            m2 = m1;
        end
        cn = c1 + DW'(1);
        rn = r2;
        mn = m2;
        if (cn >= w_dim)
        begin
            cn = '0;
            rn = r2 + DW'(1);
            mn = slot_inc(m2);
            if (rn >= h_dim)
            begin
                rn = '0;
                mn = 3'd0;
            end
        end
        col_next = cn[CW-1:0];
        row_next = rn[RW-1:0];
        slot_next = mn;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            slot_reg <= 3'd0;
        end
        else if (cmd.accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            slot_reg <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            col_pos_reg <= c1[CW-1:0];
            row_pos_reg <= r2[RW-1:0];
            slot_pos_reg <= m2;
            pix_reg <= pixel_value;
        end
    end

    // Six line banks, one per row slot, read before write at the same column.
    logic [7:0] rd_data [LINES];

    for (genvar j = 0; j < LINES; j++)
    begin : g_bank
        logic [7:0] mem [MAX_WIDTH];
        always_ff @(posedge clk)
        begin
            if (cmd.accept)
            begin
                rd_data[j] <= mem[c1[CW-1:0]];
                if (m2 == 3'(j)) mem[c1[CW-1:0]] <= pixel_value;
            end
        end
    end

    // Window shift: the newest column enters at the right.
    logic [7:0] win [WIN][WIN];
    logic [7:0] colv [WIN];

    always_comb
    begin
        logic [3:0] sel;
        for (int k = 0; k < LINES; k++)
        begin
            sel = 4'(slot_pos_reg) + 4'(k);
            if (sel >= 4'(LINES)) sel = sel - 4'(LINES);
            colv[k] = rd_data[sel[2:0]];
        end
        colv[LINES] = pix_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.shift)
        begin
            for (int y = 0; y < WIN; y++)
            begin
                for (int x = 0; x < WIN - 1; x++) win[y][x] <= win[y][x + 1];
                win[y][WIN - 1] <= colv[y];
            end
        end
    end

    logic [7:0] circ [16];
    for (genvar g = 0; g < 16; g++)
    begin : g_circ
        assign circ[g] = win[3 + CIRC_Y[g]][3 + CIRC_X[g]];
    end

    // Run search over opposite pairs.
    logic [7:0]  centre_reg;
    logic [8:0]  thd_reg;
    logic [7:0]  mask_reg;
    logic [3:0]  start_reg;
    logic [2:0]  cnt_reg;
    logic [10:0] s1_reg, s2_reg;
    logic [6:0]  guard_reg;
    logic [8:0]  thd_now;
    logic        cross_ok;
    logic [3:0]  ii;
    logic [7:0]  pa, pb;
    logic        hit;

    always_comb
    begin
        thd_now = {1'b0, win[3][3]} + {1'b0, cfg.bright_offset};
        cross_ok = ({1'b0, win[0][3]} > thd_now && {1'b0, win[6][3]} > thd_now) ||
                   ({1'b0, win[3][0]} > thd_now && {1'b0, win[3][6]} > thd_now);
        ii = start_reg + 4'(cnt_reg);
        pa = circ[ii];
        pb = circ[{~ii[3], ii[2:0]}];
        hit = ({1'b0, pa} > thd_reg) && ({1'b0, pb} > thd_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            centre_reg <= win[3][3];
            thd_reg <= thd_now;
            mask_reg <= cross_ok ? 8'hFF : 8'h00;
            start_reg <= 4'd0;
            cnt_reg <= 3'd0;
            s1_reg <= '0;
            s2_reg <= '0;
            guard_reg <= '0;
        end
        else if (cmd.run)
        begin
            guard_reg <= guard_reg + 7'd1;
            if (hit)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                s1_reg <= s1_reg + 11'(pa);
                s2_reg <= s2_reg + 11'(pb);
            end
            else
            begin
                mask_reg <= mask_reg & WRAP_MASK[ii[2:0]];
                start_reg <= ii + 4'd1;
                cnt_reg <= 3'd0;
                s1_reg <= '0;
                s2_reg <= '0;
            end
        end
    end

    // Side balance: floor(d / 5) < limit is the same as d < 5 * limit.
    logic [10:0] side_diff;
    logic [10:0] limit5;

    always_comb
    begin
        side_diff = (s1_reg >= s2_reg) ? s1_reg - s2_reg : s2_reg - s1_reg;
        limit5 = 11'({cfg.side_diff_limit, 2'b00}) + 11'(cfg.side_diff_limit);
    end

    // Arc minimum search.
    logic [1:0] step_reg;
    logic [7:0] min1_reg, min2_reg;
    logic [3:0] i1_reg, i2_reg;
    logic       f1_reg, f2_reg;
    logic [3:0] a1, a2;

    assign a1 = start_reg + 4'(RUN_LEN) + 4'(step_reg);
    assign a2 = start_reg + 4'(RUN_LEN + 8) + 4'(step_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.arc_init)
        begin
            step_reg <= 2'd0;
            min1_reg <= 8'hFF;
            min2_reg <= 8'hFF;
            f1_reg <= 1'b0;
            f2_reg <= 1'b0;
            i1_reg <= 4'd0;
            i2_reg <= 4'd0;
        end
        else if (cmd.arc_step)
        begin
            step_reg <= step_reg + 2'd1;
            if (circ[a1] < min1_reg)
            begin
                f1_reg <= 1'b1;
                min1_reg <= circ[a1];
                i1_reg <= a1;
            end
            if (circ[a2] < min2_reg)
            begin
                f2_reg <= 1'b1;
                min2_reg <= circ[a2];
                i2_reg <= a2;
            end
        end
    end

    // Direction and score.
    logic signed [3:0] x1, y1, x2, y2;
    logic signed [8:0] angle;
    logic [7:0]        score;
    logic [7:0]        m_inv;
    logic [12:0]       row_ext;
    logic [12:0]       col_ext;

    always_comb
    begin
        x1 = {CIRC_X[i1_reg][2], CIRC_X[i1_reg]};
        y1 = {CIRC_Y[i1_reg][2], CIRC_Y[i1_reg]};
        x2 = {CIRC_X[i2_reg][2], CIRC_X[i2_reg]};
        y2 = {CIRC_Y[i2_reg][2], CIRC_Y[i2_reg]};
        score = 8'd0;
        m_inv = f1_reg ? ~min1_reg : ~min2_reg;
        if (f1_reg && f2_reg)
        begin
            angle = fold_angle(x1 - x2, y1 - y2);
        end
        else if (f1_reg)
        begin
            angle = fold_angle(x1, y1);
            score = (m_inv < ~centre_reg) ? m_inv : ~centre_reg;
        end
        else if (f2_reg)
        begin
            angle = fold_angle(-x2, -y2);
            score = (m_inv < ~centre_reg) ? m_inv : ~centre_reg;
        end
        else
        begin
            angle = NO_DIR;
        end
        row_ext = 13'(row_pos_reg) - 13'd3;
        col_ext = 13'(col_pos_reg) - 13'd3;
    end

    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            point_row <= row_ext[9:0];
            point_col <= col_ext[9:0];
            angle_deg <= angle;
            point_score <= score;
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        sts.eligible = (row_pos_reg >= RW'(LINES)) && (col_pos_reg >= CW'(LINES));
        sts.run_go = (cnt_reg < 3'(RUN_LEN)) && (mask_reg != 8'h00) && !guard_reg[6];
        sts.run_hit = (cnt_reg == 3'(RUN_LEN));
        sts.diff_ok = side_diff < limit5;
        sts.arc_last = (step_reg == 2'(ARC_LAST));
        sts.out_free = !out_valid_reg || out_ready;
    end

endmodule

// File: test/circle_line_point_detector_tb.sv
`timescale 1ns / 1ps

typedef struct {
    logic [9:0]        row;
    logic [9:0]        col;
    logic signed [8:0] angle;
    logic [7:0]        score;
} line_point_t;

class point_scoreboard;
    byte unsigned  lines [6][1024];
    byte unsigned  win [7][7];
    int            col_cnt;
    int            row_cnt;
    int            bright_ofs;
    int            diff_lim;
    int            width_reg;
    int            height_reg;
    int            errors;
    line_point_t   pending [$];
    int            cx [16] = '{-3, -3, -2, -1, 0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3};
    int            cy [16] = '{0, -1, -2, -3, -3, -3, -2, -1, 0, 1, 2, 3, 3, 3, 2, 1};

    function new();
        foreach (lines[i, j]) lines[i][j] = 0;
        foreach (win[i, j]) win[i][j] = 0;
        col_cnt = 0;
        row_cnt = 0;
        bright_ofs = 20;
        diff_lim = 20;
        width_reg = 640;
        height_reg = 480;
        errors = 0;
    endfunction

    function void write_reg(clpd_pkg::clpd_reg_t idx, int value);
        case (idx)
            clpd_pkg::REG_BRIGHT_OFFSET:   bright_ofs = value & 8'hFF;
            clpd_pkg::REG_SIDE_DIFF_LIMIT: diff_lim = value & 8'hFF;
            clpd_pkg::REG_IMAGE_WIDTH:     width_reg = value & 11'h7FF;
            default:                       height_reg = value & 11'h7FF;
        endcase
    endfunction

    function int clamp_dim(int v);
        if (v < 7) return 7;
        if (v > 1024) return 1024;
        return v;
    endfunction

    function int circ(int i);
        i = i & 15;
        return win[3 + cy[i]][3 + cx[i]];
    endfunction

    function int fold_deg(int dx, int dy);
        int ax;
        int ay;
        int q;
        int d;
        bit exact;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        if (ax > 6) ax = 6;
        if (ay > 6) ay = 6;
        q = clpd_pkg::QUAD_DEG[ay][ax];
        exact = (ax == 0) || (ay == 0) || (ax == ay);
        if (dx >= 0) d = q;
        else d = exact ? 180 - q : 179 - q;
        return dy >= 0 ? d : 179 - d;
    endfunction

    // Advances the raster model by one accepted pixel and queues the point it yields.
    function void note_pixel(int pix, bit fs);
        int w;
        int h;
        int r;
        int c;
        int colv [7];
        int centre, thd, start, cnt, s1, s2, guard, ii, a, b, diff;
        int min1, min2, i1, i2, angle, score, m, cc;
        bit cross_ok, f1, f2;
        logic [7:0] msk;
        line_point_t pt;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        if (fs)
        begin
            col_cnt = 0;
            row_cnt = 0;
        end
        if (col_cnt >= w)
        begin
            col_cnt = 0;
            row_cnt++;
        end
        if (row_cnt >= h) row_cnt = 0;
        r = row_cnt;
        c = col_cnt;
        for (int k = 0; k < 6; k++) colv[k] = lines[(r + k) % 6][c];
        colv[6] = pix;
        lines[r % 6][c] = pix;
        for (int y = 0; y < 7; y++)
        begin
            for (int x = 0; x < 6; x++) win[y][x] = win[y][x + 1];
            win[y][6] = colv[y];
        end
        if (r >= 6 && c >= 6)
        begin
            centre = win[3][3];
            thd = centre + bright_ofs;
            start = 0;
            cnt = 0;
            s1 = 0;
            s2 = 0;
            guard = 0;
            cross_ok = (win[0][3] > thd && win[6][3] > thd) ||
                       (win[3][0] > thd && win[3][6] > thd);
            msk = cross_ok ? 8'hFF : 8'h00;
            while (cnt < 5 && msk != 0 && guard < 64)
            begin
                ii = (start + cnt) & 15;
                a = circ(ii);
                b = circ(ii + 8);
                guard++;
                s1 += a;
                s2 += b;
                if (a > thd && b > thd) cnt++;
                else
                begin
                    msk &= clpd_pkg::WRAP_MASK[ii & 7];
                    start = (ii + 1) & 15;
                    cnt = 0;
                    s1 = 0;
                    s2 = 0;
                end
            end
            if (cnt == 5)
            begin
                min1 = 255;
                min2 = 255;
                i1 = 0;
                i2 = 0;
                f1 = 0;
                f2 = 0;
                score = 0;
                diff = (s1 >= s2 ? s1 - s2 : s2 - s1) / 5;
                if (diff < diff_lim)
                begin
                    for (int st = 0; st < 3; st++)
                    begin
                        a = (start + 5 + st) & 15;
                        b = (start + 13 + st) & 15;
                        if (circ(a) < min1)
                        begin
                            f1 = 1;
                            min1 = circ(a);
                            i1 = a;
                        end
                        if (circ(b) < min2)
                        begin
                            f2 = 1;
                            min2 = circ(b);
                            i2 = b;
                        end
                    end
                end
                cc = 255 - centre;
                if (f1 && f2) angle = fold_deg(cx[i1] - cx[i2], cy[i1] - cy[i2]);
                else if (f1)
                begin
                    m = 255 - min1;
                    score = m < cc ? m : cc;
                    angle = fold_deg(cx[i1], cy[i1]);
                end
                else if (f2)
                begin
                    m = 255 - min2;
                    score = m < cc ? m : cc;
                    angle = fold_deg(-cx[i2], -cy[i2]);
                end
                else angle = -181;
                pt.row = 10'(r - 3);
                pt.col = 10'(c - 3);
                pt.angle = 9'(angle);
                pt.score = 8'(score);
                pending.insert(pending.size(), pt);
            end
        end
        col_cnt = c + 1;
        if (col_cnt >= w)
        begin
            col_cnt = 0;
            row_cnt = r + 1;
            if (row_cnt >= h) row_cnt = 0;
        end
    endfunction

    function void check_point(line_point_t got);
        line_point_t want;
        if (pending.size() == 0)
        begin
            $error("unexpected point row %0d col %0d", got.row, got.col);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.row !== want.row)
        begin
            $error("point_row expected %0d actual %0d", want.row, got.row);
            errors++;
        end
        if (got.col !== want.col)
        begin
            $error("point_col expected %0d actual %0d", want.col, got.col);
            errors++;
        end
        if (got.angle !== want.angle)
        begin
            $error("angle_deg expected %0d actual %0d", want.angle, got.angle);
            errors++;
        end
        if (got.score !== want.score)
        begin
            $error("point_score expected %0d actual %0d", want.score, got.score);
            errors++;
        end
    endfunction
endclass

module circle_line_point_detector_tb;
    import clpd_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    clpd_pixel_if pixel_ch ();
    clpd_point_if point_ch ();

    // The scoreboard also carries the raster model, so it sees every accepted pixel.
    point_scoreboard sb = new();

    // Main asks the receiver for one long hold-off; the receiver counts it itself.
    bit long_hold = 1'b0;
    // When set, neither side inserts idle cycles.
    bit no_idle = 1'b0;

    // Pattern of the frame being sent: dark stripes on a bright ground, or pure noise.
    int pat_a, pat_b, pat_per, pat_thick, pat_dark, pat_bright, pat_noise, pat_noisy;

    always #5 clk = ~clk;

    circle_line_point_detector i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel_ch.sink),
        .point     (point_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Both monitors sample at the edge, before the edge's nonblocking updates land.
    always @(posedge clk)
    begin
        if (rst_n && pixel_ch.valid && pixel_ch.ready)
            sb.note_pixel(pixel_ch.pixel_value, pixel_ch.frame_start);
    end

    always @(posedge clk)
    begin
        line_point_t got;
        if (rst_n && point_ch.valid && point_ch.ready)
        begin
            got.row = point_ch.point_row;
            got.col = point_ch.point_col;
            got.angle = point_ch.angle_deg;
            got.score = point_ch.point_score;
            sb.check_point(got);
        end
    end

    // Receiver: a random stall before each item, plus the one long hold-off on request.
    initial
    begin
        int stall;
        bit hold_done;
        hold_done = 1'b0;
        point_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (long_hold && !hold_done)
            begin
                hold_done = 1'b1;
                stall = 3000;
            end
            if (stall > 0)
            begin
                point_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            point_ch.ready <= 1'b1;
            @(posedge clk);
            while (!point_ch.valid) @(posedge clk);
        end
    end

    // Offers one pixel item and returns at the edge where it is taken. The valid line
    // is lowered only when a gap follows, so back-to-back items keep it high.
    task automatic send_pixel(int value, bit fs);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            pixel_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_ch.valid <= 1'b1;
        pixel_ch.pixel_value <= 8'(value);
        pixel_ch.frame_start <= fs;
        @(posedge clk);
        while (!pixel_ch.ready) @(posedge clk);
    endtask

    function automatic int frame_pixel(int r, int c);
        int v;
        int m;
        if (pat_noisy) return $urandom_range(0, 255);
        m = ((pat_a * r + pat_b * c) % pat_per + pat_per) % pat_per;
        v = (m < pat_thick ? pat_dark : pat_bright) + $urandom_range(0, pat_noise);
        return v > 255 ? 255 : v;
    endfunction

    task automatic pick_pattern();
        pat_noisy = ($urandom_range(0, 5) == 0);
        pat_a = $urandom_range(0, 4) - 2;
        pat_b = $urandom_range(0, 4) - 2;
        if (pat_a == 0 && pat_b == 0) pat_a = 1;
        pat_per = $urandom_range(5, 12);
        pat_thick = $urandom_range(1, 2);
        pat_dark = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 90);
        pat_bright = $urandom_range(120, 255);
        pat_noise = $urandom_range(0, 60);
    endtask

    // Sends one frame of w x h pixels. Some frames are cut short, and a rare item
    // raises frame_start in the middle of a frame; both restart the raster.
    task automatic send_frame(int w, int h);
        int total;
        int n;
        bit fs;
        pick_pattern();
        total = w * h;
        if ($urandom_range(0, 7) == 0) total = $urandom_range(1, total);
        for (n = 0; n < total; n++)
        begin
            fs = (n == 0) || ($urandom_range(0, 999) == 0);
            send_pixel(frame_pixel(n / w, n % w), fs);
        end
    endtask

    task automatic wait_idle();
        pixel_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        // The block may still be working on a pixel that yields no point.
        repeat (150) @(posedge clk);
    endtask

    task automatic cfg_write(clpd_reg_t idx, int value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        sb.write_reg(idx, value);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(int bo, int sdl, int w, int h);
        wait_idle();
        cfg_write(REG_BRIGHT_OFFSET, bo);
        cfg_write(REG_SIDE_DIFF_LIMIT, sdl);
        cfg_write(REG_IMAGE_WIDTH, w);
        cfg_write(REG_IMAGE_HEIGHT, h);
    endtask

    function automatic int pick_level();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 255;
            default: return $urandom_range(1, 60);
        endcase
    endfunction

    initial
    begin
        int items;
        int w;
        int h;
        int n;
        pixel_ch.valid = 1'b0;
        pixel_ch.pixel_value = '0;
        pixel_ch.frame_start = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a 7x7 frame with one dark row through the centre on a white
        // ground, so the single testable centre is a line point with a clear run.
        set_config(20, 20, 7, 7);
        for (n = 0; n < 49; n++)
            send_pixel((n / 7 == 3) ? 0 : 255, n == 0);

        // Geometry registers out of range on both sides: clamps to 7 x 1024,
        // followed by the top 20 rows of such a frame.
        no_idle = 1'b1;
        set_config(10, 255, 3, 2047);
        send_frame(7, 20);
        no_idle = 1'b0;

        // Random phases of small frames under varied thresholds.
        items = 0;
        while (items < 400)
        begin
            w = $urandom_range(7, 16);
            h = $urandom_range(7, 14);
            set_config(pick_level(), pick_level(), w, h);
            no_idle = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 3))
            begin
                send_frame(w, h);
                items += w * h;
            end
        end

        // Long receiver hold-off on a dense frame while pixels keep coming.
        set_config(5, 255, 16, 16);
        no_idle = 1'b1;
        long_hold = 1'b1;
        pat_noisy = 0;
        pat_a = 1;
        pat_b = 0;
        pat_per = 4;
        pat_thick = 1;
        pat_dark = 0;
        pat_bright = 200;
        pat_noise = 30;
        for (n = 0; n < 256; n++)
            send_pixel(frame_pixel(n / 16, n % 16), n == 0);
        no_idle = 1'b0;

        wait_idle();
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #60_000_000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
